// File: design/modexp_pkg.sv
package modexp_pkg;

   // Datapath widths: modulus, base and running value share MOD_WIDTH bits.
   localparam int MOD_WIDTH = 32;
   localparam int EXP_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int MUL_CNT_WIDTH = $clog2(MOD_WIDTH);
   localparam int EXP_CNT_WIDTH = $clog2(EXP_WIDTH);

   // Configuration port: one 32-bit register, selected by the word address.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_INDEX_MODULUS = 1'b0;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] base_value;
      logic [FIELD_WIDTH-1:0] exponent;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power_result;
      logic                   modulus_error;
   } rsp_payload_type;

   // Operation of the shared modular multiplier.
   typedef enum logic [1:0] {
      MODE_REDUCE = 2'd0,
      MODE_SQUARE = 2'd1,
      MODE_MULT   = 2'd2
   } mul_mode_type;

   typedef struct packed {
      logic         load;
      logic         mul_init;
      mul_mode_type init_mode;
      logic         mul_step;
      mul_mode_type step_mode;
      logic         exp_shift;
      logic         out_load;
   } modexp_cmd_type;

   typedef struct packed {
      logic special;
      logic exp_msb;
      logic exp_last;
      logic mul_last;
   } modexp_status_type;

endpackage

// File: design/modexp_dp.sv
module modexp_dp (
   input  logic                         clock,
   input  modexp_pkg::modexp_cmd_type    cmd,
   output modexp_pkg::modexp_status_type status,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0] modulus,
   input  modexp_pkg::req_payload_type   req_payload,
   output modexp_pkg::rsp_payload_type   rsp_payload
);
   import modexp_pkg::*;

   logic [MOD_WIDTH-1:0]     mod_val;
   logic [MOD_WIDTH-1:0]     req_base;
   logic [EXP_WIDTH-1:0]     req_exp;
   logic [MOD_WIDTH-1:0]     base_ff, base_in;
   logic [MOD_WIDTH-1:0]     acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]     part_ff, part_in;
   logic [MOD_WIDTH-1:0]     op_ff, op_in;
   logic [MUL_CNT_WIDTH-1:0] mul_cnt_ff, mul_cnt_in;
   logic [EXP_WIDTH-1:0]     exp_ff, exp_in;
   logic [EXP_CNT_WIDTH-1:0] exp_cnt_ff, exp_cnt_in;
   logic                     err_ff, err_in;
   logic                     one_ff, one_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic [MOD_WIDTH-1:0]     addend;
   logic                     op_bit;
   logic                     carry_bit;
   logic                     add_bit;
   logic [MOD_WIDTH:0]       dbl;
   logic [MOD_WIDTH-1:0]     dbl_red;
   logic [MOD_WIDTH:0]       sum;
   logic [MOD_WIDTH-1:0]     sum_red;
   logic [MOD_WIDTH-1:0]     part_next;
   logic                     mul_last;
   logic [MOD_WIDTH-1:0]     result_val;

   assign mod_val  = MOD_WIDTH'(modulus);
   assign req_base = MOD_WIDTH'(req_payload.base_value);
   assign req_exp  = EXP_WIDTH'(req_payload.exponent);

   // One multiplier step: double with an optional shifted-in bit, then add.
   // Both partial values stay below the modulus, so one subtract reduces each.
   // The bits come from op_ff and the addend is always the running value, so a
   // multiply by the base shifts the base out and adds the freshly squared value.
   always_comb begin
      addend    = acc_ff;
      op_bit    = op_ff[MOD_WIDTH-1];
      carry_bit = (cmd.step_mode == MODE_REDUCE) ? op_bit : 1'b0;
      add_bit   = (cmd.step_mode == MODE_REDUCE) ? 1'b0 : op_bit;
      dbl       = {part_ff, carry_bit};
      dbl_red   = (dbl >= {1'b0, mod_val}) ? MOD_WIDTH'(dbl - {1'b0, mod_val})
                                           : MOD_WIDTH'(dbl);
      sum       = {1'b0, dbl_red} + {1'b0, addend};
      sum_red   = (sum >= {1'b0, mod_val}) ? MOD_WIDTH'(sum - {1'b0, mod_val})
                                           : MOD_WIDTH'(sum);
      part_next = add_bit ? sum_red : dbl_red;
   end

   assign mul_last = (mul_cnt_ff == MUL_CNT_WIDTH'(MOD_WIDTH - 1));

   assign status.special  = (mod_val == '0) || (req_exp == '0);
   assign status.exp_msb  = exp_ff[EXP_WIDTH-1];
   assign status.exp_last = (exp_cnt_ff == '0);
   assign status.mul_last = mul_last;

   // Result selection for the output register.
   assign result_val = err_ff ? '0 : (one_ff ? MOD_WIDTH'(1) : acc_ff);

   // Next-state logic for the working registers.
   always_comb begin
      base_in    = base_ff;
      acc_in     = acc_ff;
      part_in    = part_ff;
      op_in      = op_ff;
      mul_cnt_in = mul_cnt_ff;
      exp_in     = exp_ff;
      exp_cnt_in = exp_cnt_ff;
      err_in     = err_ff;
      one_in     = one_ff;
      rsp_in     = rsp_ff;

      if (cmd.load) begin
         op_in      = req_base;
         part_in    = '0;
         mul_cnt_in = '0;
         exp_in     = req_exp;
         exp_cnt_in = EXP_CNT_WIDTH'(EXP_WIDTH - 1);
         err_in     = (mod_val == '0);
         one_in     = (req_exp == '0);
      end

      if (cmd.mul_step) begin
         part_in    = part_next;
         op_in      = {op_ff[MOD_WIDTH-2:0], 1'b0};
         mul_cnt_in = mul_cnt_ff + 1'b1;
         if (mul_last) begin
            acc_in = part_next;
            if (cmd.step_mode == MODE_REDUCE) begin
               base_in = part_next;
            end
         end
      end

      // A new multiplication may start in the cycle the previous one ends.
      if (cmd.mul_init) begin
         part_in    = '0;
         mul_cnt_in = '0;
         op_in      = (cmd.init_mode == MODE_MULT) ? base_ff : acc_ff;
      end

      if (cmd.exp_shift) begin
         exp_in     = {exp_ff[EXP_WIDTH-2:0], 1'b0};
         exp_cnt_in = exp_cnt_ff - 1'b1;
      end

      if (cmd.out_load) begin
         rsp_in.power_result  = FIELD_WIDTH'(result_val);
         rsp_in.modulus_error = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      part_ff    <= part_in;
      op_ff      <= op_in;
      mul_cnt_ff <= mul_cnt_in;
      exp_ff     <= exp_in;
      exp_cnt_ff <= exp_cnt_in;
      err_ff     <= err_in;
      one_ff     <= one_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: design/modexp_ctrl.sv
module modexp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  modexp_pkg::modexp_status_type status,
   output modexp_pkg::modexp_cmd_type    cmd
);
   import modexp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_REDUCE = 7'b0000010,
      ST_NORM   = 7'b0000100,
      ST_NEXT   = 7'b0001000,
      ST_SQUARE = 7'b0010000,
      ST_MULT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Sequencing of reduce, normalize, square and multiply phases.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.init_mode = MODE_SQUARE;
      cmd.step_mode = MODE_SQUARE;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.special ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.mul_step  = 1'b1;
            cmd.step_mode = MODE_REDUCE;
            if (status.mul_last) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // Skip leading zero bits of the exponent.
            if (status.exp_msb) begin
               state_in = ST_NEXT;
            end else begin
               cmd.exp_shift = 1'b1;
            end
         end
         ST_NEXT: begin
            if (status.exp_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.exp_shift = 1'b1;
               cmd.mul_init  = 1'b1;
               cmd.init_mode = MODE_SQUARE;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.mul_step  = 1'b1;
            cmd.step_mode = MODE_SQUARE;
            if (status.mul_last) begin
               if (status.exp_msb) begin
                  cmd.mul_init  = 1'b1;
                  cmd.init_mode = MODE_MULT;
                  state_in      = ST_MULT;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_MULT: begin
            cmd.mul_step  = 1'b1;
            cmd.step_mode = MODE_MULT;
            if (status.mul_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_FINISH: begin
            // Load the output register once the previous result has left.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/modular_exponentiation.sv
// A zero modulus or zero exponent goes straight to the result. Otherwise the base is reduced and
// leading zero exponent bits are skipped; each lower bit needs a square and, if set, a multiply.
// Each modular multiplication steps through its operand one bit per cycle.
// Requests are handled one at a time; the next is accepted as the result is presented.
// Reset (synchronous, active high) clears the sequencer and output valid, and sets modulus to 1.
module modular_exponentiation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  modexp_pkg::req_payload_type           req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output modexp_pkg::rsp_payload_type           rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [modexp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [modexp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [modexp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                  csr_pready
);
   import modexp_pkg::*;

   logic [FIELD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                   csr_hit;
   modexp_cmd_type         cmd;
   modexp_status_type      status;

   // Register file: the modulus sits at word address zero.
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_INDEX_MODULUS);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(modulus_ff) : '0;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         modulus_in = FIELD_WIDTH'(csr_pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= FIELD_WIDTH'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .modulus     (modulus_ff),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: dv/tb_modular_exponentiation.sv
module tb_modular_exponentiation;
   import modexp_pkg::*;

   // A register index that the block does not decode.
   localparam int CSR_INDEX_UNUSED = 1;
   localparam int MAX_REPORTED = 10;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Local copy of the modulus register and the results still owed by the block.
   logic [FIELD_WIDTH-1:0]    modulus_setting = 1;
   rsp_payload_type           pending_powers[$];
   bit                        idling_enabled = 1'b1;
   int                        stall_left = 0;
   int                        mismatch_count = 0;
   int                        request_count = 0;
   int                        error_count = 0;
   int                        setting_count = 0;

   modular_exponentiation i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Left-to-right square and multiply with exact 64-bit products.
   function automatic rsp_payload_type predict_power(input logic [FIELD_WIDTH-1:0] base_in,
                                                     input logic [FIELD_WIDTH-1:0] exp_in,
                                                     input logic [FIELD_WIDTH-1:0] mod_in);
      rsp_payload_type outcome;
      bit [63:0]       m;
      bit [63:0]       b;
      bit [63:0]       r;
      int              top;
      outcome.power_result = '0;
      outcome.modulus_error = 1'b0;
      if (mod_in == 0) begin
         outcome.modulus_error = 1'b1;
         return outcome;
      end
      if (exp_in == 0) begin
         outcome.power_result = 1;
         return outcome;
      end
      m = mod_in;
      b = base_in % m;
      r = b;
      top = EXP_WIDTH - 1;
      while (top > 0 && !exp_in[top])
         top--;
      for (int k = top - 1; k >= 0; k--) begin
         r = (r * r) % m;
         if (exp_in[k])
            r = (r * b) % m;
      end
      outcome.power_result = r[FIELD_WIDTH-1:0];
      return outcome;
   endfunction

   // Mostly short gaps, now and then a long one; none while idling is off.
   function automatic int pick_gap();
      int roll;
      if (!idling_enabled)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Short exponents keep the run fast; a fifth are full width to reach every bit.
   function automatic logic [FIELD_WIDTH-1:0] pick_exponent();
      int roll;
      int bits;
      roll = $urandom_range(0, 99);
      bits = $urandom_range(1, 12);
      if (roll < 20)
         return $urandom;
      if (roll < 25)
         return $urandom_range(0, 1);
      return $urandom & ((32'd1 << bits) - 1);
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] pick_base(input logic [FIELD_WIDTH-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return m - 1;
         2: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [FIELD_WIDTH-1:0] expected,
                                input logic [FIELD_WIDTH-1:0] actual);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED)
         $display("Mismatch in %s: expected 0x%08h, got 0x%08h", what, expected, actual);
   endtask

   // Send one request after a random gap and record its expected result once accepted.
   task automatic send_request(input logic [FIELD_WIDTH-1:0] base_in,
                               input logic [FIELD_WIDTH-1:0] exp_in);
      int              gap;
      rsp_payload_type expected;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{base_value: base_in, exponent: exp_in};
      do @(posedge clock); while (req_stall);
      expected = predict_power(base_in, exp_in, modulus_setting);
      pending_powers.push_back(expected);
      request_count++;
      if (expected.modulus_error)
         error_count++;
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_powers.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input int index, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'(index * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == CSR_INDEX_MODULUS)
         modulus_setting = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_modulus_readback();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_WIDTH'(CSR_INDEX_MODULUS * 4);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== modulus_setting)
         note_mismatch("modulus readback", modulus_setting, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_modulus(input logic [FIELD_WIDTH-1:0] value);
      wait_for_results();
      write_csr(CSR_INDEX_MODULUS, value);
      check_modulus_readback();
      setting_count++;
   endtask

   // The reset value of the modulus is one: zero exponent gives 1, others give 0.
   task automatic test_reset_modulus();
      check_modulus_readback();
      send_request(32'd5, 32'd0);
      send_request(32'hFFFF_FFFF, 32'd7);
      send_request(32'd0, 32'hFFFF_FFFF);
   endtask

   // A zero modulus flags an error whatever the exponent.
   task automatic test_zero_modulus();
      set_modulus(32'd0);
      send_request(32'd9, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'd2, 32'd3);
   endtask

   // A write to an undecoded register must leave the modulus alone.
   task automatic test_unused_register();
      set_modulus(32'd97);
      wait_for_results();
      write_csr(CSR_INDEX_UNUSED, 32'd0);
      check_modulus_readback();
      send_request(32'd10, 32'd5);
   endtask

   // Full-width operands, base reduction and a textbook key pair.
   task automatic test_extremes();
      set_modulus(32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'h8000_0000);
      send_request(32'd1, 32'hFFFF_FFFF);
      send_request(32'd0, 32'd0);
      send_request(32'd2, 32'd31);
      send_request(32'd2, 32'd32);
      set_modulus(32'd3233);
      send_request(32'd65, 32'd17);
      send_request(32'd2790, 32'd2753);
      send_request(32'd5000, 32'd1);
      set_modulus(32'd2);
      send_request(32'd3, 32'd1);
   endtask

   // Random requests under a series of moduli, with and without idling.
   task automatic test_random_moduli();
      logic [FIELD_WIDTH-1:0] next_modulus;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: next_modulus = 32'hFFFF_FFFF;
            1: next_modulus = 32'd2;
            2: next_modulus = $urandom | 32'h8000_0001;
            3: next_modulus = 32'd3233;
            4: next_modulus = 32'h8000_0000;
            5: next_modulus = $urandom_range(3, 255);
            6: next_modulus = 32'd1;
            7: next_modulus = 32'd0;
            default: next_modulus = $urandom;
         endcase
         set_modulus(next_modulus);
         idling_enabled = (phase % 3) != 2;
         repeat (28)
            send_request(pick_base(next_modulus), pick_exponent());
      end
      idling_enabled = 1'b1;
   endtask

   // Random backpressure on the result side.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_payload_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            note_mismatch("result with no request outstanding", '0, rsp_payload.power_result);
         end else begin
            expected = pending_powers.pop_front();
            if (rsp_payload.power_result !== expected.power_result)
               note_mismatch("power_result", expected.power_result, rsp_payload.power_result);
            if (rsp_payload.modulus_error !== expected.modulus_error)
               note_mismatch("modulus_error", expected.modulus_error, rsp_payload.modulus_error);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_modulus();
      test_zero_modulus();
      test_unused_register();
      test_extremes();
      test_random_moduli();
      wait_for_results();
      repeat (50) @(posedge clock);
      if (pending_powers.size() != 0)
         mismatch_count++;
      $display("Checked %0d requests under %0d modulus settings.", request_count, setting_count);
      $display("%0d requests hit the zero-modulus error, %0d mismatches seen.",
               error_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Safety net in case the block hangs.
   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
